// File: rtl/bfv_pkg.sv
package bfv_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int IN_W       = 32;
	localparam int OUT_W      = 30;
	localparam int YIELD_W    = 27;
	localparam int VISC_W     = 30;
	localparam int GEOM_W     = 17;
	localparam int CFG_W      = 30;
	localparam int CFG_IDX_W  = 3;
	localparam int SUM_W      = 2 * IN_W;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_N_W    = ROOT_W + FRAC_BITS;
	localparam int DIV_D_W    = 32;
	localparam int DIV_STEPS  = DIV_N_W;
	localparam int WIDE_W     = IN_W + 4;

	localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_YIELD = 3'd0,
		REG_CAP   = 3'd1,
		REG_BASE  = 3'd2,
		REG_CELL  = 3'd3,
		REG_METRIC = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                valid;
		logic [SUM_W-1:0]    x;
		logic [ROOT_W:0]     rem;
		logic [ROOT_W-1:0]   root;
	} sqrt_stage_t;

	typedef struct packed {
		logic                valid;
		logic                tag;
		logic [DIV_D_W-1:0]  d;
		logic [DIV_N_W-1:0]  n;
		logic [DIV_D_W-1:0]  r;
		logic [DIV_N_W-1:0]  q;
	} div_stage_t;

	function automatic logic signed [IN_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = {{(WIDE_W-IN_W+1){1'b0}}, {(IN_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi)
			return hi[IN_W-1:0];
		else if (v < lo)
			return lo[IN_W-1:0];
		else
			return v[IN_W-1:0];
	endfunction

endpackage

// File: rtl/bingham_face_viscosity_core.sv
// channel | handshake            | payload
// in      | in_valid / in_stall  | ux_* , uy_* (12 x 32b signed Q16.16)
// out     | out_valid / out_stall| face_viscosity (30b), at_cap (1b)
// cfg     | cfg_we               | cfg_index, cfg_data
// One face per cycle while the output is not stalled.
// Latency is set by the square-root chain and the two divider chains,
// one result bit per cell.
// Reset clears all valid bits and loads register defaults.
// A stalled valid output freezes every stage; in_stall is high only then.
module bingham_face_viscosity_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [bfv_pkg::IN_W-1:0]  ux_here,
	input  logic signed [bfv_pkg::IN_W-1:0]  ux_left,
	input  logic signed [bfv_pkg::IN_W-1:0]  ux_up,
	input  logic signed [bfv_pkg::IN_W-1:0]  ux_down,
	input  logic signed [bfv_pkg::IN_W-1:0]  ux_left_up,
	input  logic signed [bfv_pkg::IN_W-1:0]  ux_left_down,
	input  logic signed [bfv_pkg::IN_W-1:0]  uy_here,
	input  logic signed [bfv_pkg::IN_W-1:0]  uy_left,
	input  logic signed [bfv_pkg::IN_W-1:0]  uy_up,
	input  logic signed [bfv_pkg::IN_W-1:0]  uy_down,
	input  logic signed [bfv_pkg::IN_W-1:0]  uy_left_up,
	input  logic signed [bfv_pkg::IN_W-1:0]  uy_left_down,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [bfv_pkg::OUT_W-1:0]        face_viscosity,
	output logic                             at_cap,
	input  logic                             cfg_we,
	input  logic [bfv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bfv_pkg::CFG_W-1:0]        cfg_data
);
	import bfv_pkg::*;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [31:0]      U32_MAX = '1;
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	logic [YIELD_W-1:0] yield_q;
	logic [VISC_W-1:0]  cap_q;
	logic [VISC_W-1:0]  base_q;
	logic [GEOM_W-1:0]  cell_q;
	logic [GEOM_W-1:0]  metric_q;

	logic adv;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yield_q  <= '0;
			cap_q    <= VISC_W'(6553600);
			base_q   <= VISC_W'(65536);
			cell_q   <= GEOM_W'(1024);
			metric_q <= GEOM_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_YIELD:  yield_q  <= cfg_data[YIELD_W-1:0];
				REG_CAP:    cap_q    <= cfg_data[VISC_W-1:0];
				REG_BASE:   base_q   <= cfg_data[VISC_W-1:0];
				REG_CELL:   cell_q   <= cfg_data[GEOM_W-1:0];
				REG_METRIC: metric_q <= cfg_data[GEOM_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	// strain terms
	logic signed [WIDE_W-1:0] a11, a22, a12;
	logic signed [IN_W-1:0]   d11_s1, d22_s1, d12_s1;
	logic                     valid_s1;

	always_comb begin
		a11 = WIDE_W'(ux_here) - WIDE_W'(ux_left);
		a22 = (WIDE_W'(uy_up) - WIDE_W'(uy_down)) + (WIDE_W'(uy_left_up) - WIDE_W'(uy_left_down));
		a12 = (WIDE_W'(ux_up) - WIDE_W'(ux_down)) + (WIDE_W'(ux_left_up) - WIDE_W'(ux_left_down))
			+ ((WIDE_W'(uy_here) - WIDE_W'(uy_left)) <<< 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			d11_s1 <= sat_s32(a11);
			d22_s1 <= sat_s32(a22 >>> 2);
			d12_s1 <= sat_s32(a12 >>> 3);
		end
	end

	// squares
	logic [IN_W-1:0]  m11, m22, m12;
	logic [SUM_W-1:0] sq11_s2, sq22_s2, sq12_s2;
	logic             valid_s2;

	always_comb begin
		m11 = d11_s1[IN_W-1] ? IN_W'(-d11_s1) : IN_W'(d11_s1);
		m22 = d22_s1[IN_W-1] ? IN_W'(-d22_s1) : IN_W'(d22_s1);
		m12 = d12_s1[IN_W-1] ? IN_W'(-d12_s1) : IN_W'(d12_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq11_s2 <= SUM_W'(m11) * SUM_W'(m11);
			sq22_s2 <= SUM_W'(m22) * SUM_W'(m22);
			sq12_s2 <= SUM_W'(m12) * SUM_W'(m12);
		end
	end

	// saturated sum of squares
	logic [SUM_W+1:0] tot;
	logic [SUM_W-1:0] sum_s3;
	logic             valid_s3;

	assign tot = (SUM_W+2)'(sq11_s2) + (SUM_W+2)'(sq22_s2) + ((SUM_W+2)'(sq12_s2) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv)
			sum_s3 <= (tot[SUM_W+1:SUM_W] != 2'b00) ? SUM_MAX : tot[SUM_W-1:0];
	end

	// square-root chain
	sqrt_stage_t sq_chain [0:SQRT_STEPS];

	always_comb begin
		sq_chain[0].valid = valid_s3;
		sq_chain[0].x     = sum_s3;
		sq_chain[0].rem   = '0;
		sq_chain[0].root  = '0;
	end

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		bfv_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.prev  (sq_chain[i]),
			.next  (sq_chain[i+1])
		);
	end

	// strain invariant divider: (root << FRAC_BITS) / cell_size
	div_stage_t dv1_chain [0:DIV_STEPS];
	logic [GEOM_W-1:0] h;

	assign h = (cell_q == '0) ? GEOM_W'(1) : cell_q;

	always_comb begin
		dv1_chain[0].valid = sq_chain[SQRT_STEPS].valid;
		dv1_chain[0].tag   = 1'b0;
		dv1_chain[0].d     = DIV_D_W'(h);
		dv1_chain[0].n     = {sq_chain[SQRT_STEPS].root, FRAC_BITS'(0)};
		dv1_chain[0].r     = '0;
		dv1_chain[0].q     = '0;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div1
		bfv_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.prev  (dv1_chain[i]),
			.next  (dv1_chain[i+1])
		);
	end

	logic [DIV_N_W-1:0] q1;
	logic [31:0]        d2_s4;
	logic               valid_s4;

	assign q1 = dv1_chain[DIV_STEPS].q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (adv)
			valid_s4 <= dv1_chain[DIV_STEPS].valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			d2_s4 <= (q1[DIV_N_W-1:32] != '0) ? U32_MAX : q1[31:0];
	end

	// yield divider: (yield << FRAC_BITS) / D2
	div_stage_t dv2_chain [0:DIV_STEPS];

	always_comb begin
		dv2_chain[0].valid = valid_s4;
		dv2_chain[0].tag   = (d2_s4 == '0);
		dv2_chain[0].d     = d2_s4;
		dv2_chain[0].n     = DIV_N_W'({yield_q, FRAC_BITS'(0)});
		dv2_chain[0].r     = '0;
		dv2_chain[0].q     = '0;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div2
		bfv_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.prev  (dv2_chain[i]),
			.next  (dv2_chain[i+1])
		);
	end

	logic [DIV_N_W-1:0] q2;
	logic [31:0]        q_s5;
	logic               z_s5;
	logic               valid_s5;

	assign q2 = dv2_chain[DIV_STEPS].q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (adv)
			valid_s5 <= dv2_chain[DIV_STEPS].valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s5 <= (q2[DIV_N_W-1:32] != '0) ? U32_MAX : q2[31:0];
			z_s5 <= dv2_chain[DIV_STEPS].tag;
		end
	end

	// yield term = q / sqrt2
	logic [63:0] tprod;
	logic [31:0] term_s6;
	logic        z_s6;
	logic        valid_s6;

	assign tprod = 64'(q_s5) * 64'(INV_SQRT2_Q32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s6 <= 1'b0;
		else if (adv)
			valid_s6 <= valid_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s6 <= tprod[63:32];
			z_s6    <= z_s5;
		end
	end

	// base + term, capping
	logic [32:0] mu_sum;
	logic [32:0] mu_nx;
	logic        cap_nx;
	logic [32:0] mu_s7;
	logic        cap_s7;
	logic        z_s7;
	logic        valid_s7;

	always_comb begin
		mu_sum = 33'(base_q) + 33'(term_s6);
		if (z_s6) begin
			cap_nx = (yield_q != '0);
			mu_nx  = cap_nx ? 33'(cap_q) : 33'(base_q);
		end else if (mu_sum >= 33'(cap_q)) begin
			cap_nx = 1'b1;
			mu_nx  = 33'(cap_q);
		end else begin
			cap_nx = 1'b0;
			mu_nx  = mu_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s7 <= 1'b0;
		else if (adv)
			valid_s7 <= valid_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mu_s7  <= mu_nx;
			cap_s7 <= cap_nx;
			z_s7   <= z_s6;
		end
	end

	// metric scaling, output register
	logic [GEOM_W+32:0] fprod;
	logic [GEOM_W+16:0] fsh;
	logic               out_valid_q;
	logic [OUT_W-1:0]   face_viscosity_q;
	logic               at_cap_q;

	assign fprod = (GEOM_W+33)'(metric_q) * (GEOM_W+33)'(mu_s7);
	assign fsh   = fprod[GEOM_W+32:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= valid_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			face_viscosity_q <= (fsh > (GEOM_W+17)'(OUT_MAX)) ? OUT_MAX : fsh[OUT_W-1:0];
			at_cap_q         <= cap_s7;
		end
	end

	assign out_valid      = out_valid_q;
	assign face_viscosity = face_viscosity_q;
	assign at_cap         = at_cap_q;

	logic [GEOM_W+VISC_W-1:0] cap_prod;
	logic [GEOM_W+VISC_W-FRAC_BITS-1:0] cap_sh;
	logic [OUT_W-1:0]         cap_fv;

	assign cap_prod = (GEOM_W+VISC_W)'(metric_q) * (GEOM_W+VISC_W)'(cap_q);
	assign cap_sh   = cap_prod[GEOM_W+VISC_W-1:FRAC_BITS];
	assign cap_fv   = (cap_sh > (GEOM_W+VISC_W-FRAC_BITS)'(OUT_MAX)) ? OUT_MAX
		: cap_sh[OUT_W-1:0];

`ifndef NO_ASSERTIONS
	a_cap_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_cap |-> face_viscosity == cap_fv)
		else $error("capped result differs from scaled cap");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_chain[SQRT_STEPS].valid |->
			sq_chain[SQRT_STEPS].rem <= {sq_chain[SQRT_STEPS].root, 1'b0})
		else $error("square-root remainder out of range");

	a_uncapped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && !cap_s7 |-> (mu_s7 < 33'(cap_q)) || (z_s7 && yield_q == '0))
		else $error("uncapped viscosity at or above cap");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s7 |=> out_valid)
		else $error("result lost before output register");
`endif

endmodule

// File: rtl/bfv_sqrt_cell.sv
module bfv_sqrt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  bfv_pkg::sqrt_stage_t prev,
	output bfv_pkg::sqrt_stage_t next
);
	import bfv_pkg::*;

	logic [ROOT_W+2:0] rs;
	logic [ROOT_W+2:0] trial;
	logic              ge;
	sqrt_stage_t       nx;
	logic              valid_q;
	sqrt_stage_t       data_q;

	always_comb begin
		rs       = {prev.rem, prev.x[SUM_W-1 -: 2]};
		trial    = {1'b0, prev.root, 2'b01};
		ge       = rs >= trial;
		nx.valid = prev.valid;
		nx.x     = {prev.x[SUM_W-3:0], 2'b00};
		nx.rem   = ge ? (ROOT_W+1)'(rs - trial) : (ROOT_W+1)'(rs);
		nx.root  = {prev.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= prev.valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			data_q <= nx;
	end

	always_comb begin
		next       = data_q;
		next.valid = valid_q;
	end

endmodule

// File: rtl/bfv_div_cell.sv
module bfv_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  bfv_pkg::div_stage_t prev,
	output bfv_pkg::div_stage_t next
);
	import bfv_pkg::*;

	logic [DIV_D_W:0] rs;
	logic             ge;
	div_stage_t       nx;
	logic             valid_q;
	div_stage_t       data_q;

	always_comb begin
		rs       = {prev.r, prev.n[DIV_N_W-1]};
		ge       = rs >= {1'b0, prev.d};
		nx       = prev;
		nx.n     = {prev.n[DIV_N_W-2:0], 1'b0};
		nx.r     = ge ? DIV_D_W'(rs - {1'b0, prev.d}) : DIV_D_W'(rs);
		nx.q     = {prev.q[DIV_N_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= prev.valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			data_q <= nx;
	end

	always_comb begin
		next       = data_q;
		next.valid = valid_q;
	end

endmodule
